>>> sv/srarq_pkg.sv
`default_nettype none

package srarq_pkg;

   // field widths fixed by the interface
   localparam int CMD_W      = 2;
   localparam int TOTAL_W    = 9;
   localparam int TIMEOUT_W  = 16;
   localparam int PAYLOAD_W  = 48;
   localparam int RX_W       = 32;
   localparam int SEQ_W      = 8;
   localparam int INDEX_W    = 8;
   localparam int COUNT_W    = 9;
   localparam int TICK_W     = 32;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 1;

   // register reset values
   localparam logic [TOTAL_W-1:0]   TOTAL_RESET   = 9'd1;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd1000;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_FRAMES  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_TICKS = 1'b1;

   // message decoding and sequence characters
   localparam logic [23:0]      ACK_TAG    = 24'h41434B;
   localparam logic [SEQ_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [SEQ_W-1:0] CHAR_SEVEN = 8'h37;

   // payload bytes kept per frame
   localparam int PAYLOAD_BYTES = 6;
   localparam logic [PAYLOAD_W-1:0] PAYLOAD_MASK =
      (PAYLOAD_BYTES >= 6) ? {PAYLOAD_W{1'b1}}
                           : ((48'd1 << (8 * PAYLOAD_BYTES)) - 48'd1);

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD = 2'd0,
      CMD_MSG  = 2'd1,
      CMD_TICK = 2'd2,
      CMD_NONE = 2'd3
   } cmd_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_LOAD,
      ST_ACK_RD,
      ST_ACK_WR,
      ST_SL_RD,
      ST_SL_CHK,
      ST_FIN,
      ST_STATUS,
      ST_TK_INC,
      ST_TK_RD,
      ST_TK_CHK,
      ST_EM_SEL,
      ST_EM_OUT
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic clr_step;
      logic latch_in;
      logic load_do;
      logic ack_rd;
      logic ack_wr;
      logic sl_rd;
      logic sl_adv;
      logic flag_upd;
      logic emit_status;
      logic tk_inc;
      logic tk_rd;
      logic tk_chk;
      logic k_clear;
      logic k_step;
      logic em_rd;
      logic em_out;
   } dp_ctl_type;

   // status from datapath to controller
   typedef struct packed {
      logic    clear_done;
      cmd_type cmd;
      logic    sl_more;
      logic    sl_acked;
      logic    tk_more;
      logic    mask_zero;
      logic    mask_bit;
   } dp_sts_type;

endpackage

`default_nettype wire

>>> sv/srarq_ram.sv
`default_nettype none

module srarq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> sv/srarq_ctrl.sv
`default_nettype none

module srarq_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   output srarq_pkg::dp_ctl_type       ctl,
   input  wire srarq_pkg::dp_sts_type  sts
);

   srarq_pkg::state_type state_ff;
   srarq_pkg::state_type state_in;

   // state register, clearing pass first after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= srarq_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         srarq_pkg::ST_CLEAR: begin
            if (sts.clear_done) state_in = srarq_pkg::ST_IDLE;
         end
         srarq_pkg::ST_IDLE: begin
            if (start) state_in = srarq_pkg::ST_DECODE;
         end
         srarq_pkg::ST_DECODE: begin
            case (sts.cmd)
               srarq_pkg::CMD_LOAD: state_in = srarq_pkg::ST_LOAD;
               srarq_pkg::CMD_MSG:  state_in = srarq_pkg::ST_ACK_RD;
               srarq_pkg::CMD_TICK: state_in = srarq_pkg::ST_TK_INC;
               default:             state_in = srarq_pkg::ST_IDLE;
            endcase
         end
         srarq_pkg::ST_LOAD:   state_in = srarq_pkg::ST_STATUS;
         srarq_pkg::ST_ACK_RD: state_in = srarq_pkg::ST_ACK_WR;
         srarq_pkg::ST_ACK_WR: state_in = srarq_pkg::ST_SL_RD;
         srarq_pkg::ST_SL_RD: begin
            state_in = sts.sl_more ? srarq_pkg::ST_SL_CHK : srarq_pkg::ST_FIN;
         end
         srarq_pkg::ST_SL_CHK: begin
            state_in = sts.sl_acked ? srarq_pkg::ST_SL_RD : srarq_pkg::ST_FIN;
         end
         srarq_pkg::ST_FIN:    state_in = srarq_pkg::ST_STATUS;
         srarq_pkg::ST_STATUS: state_in = srarq_pkg::ST_IDLE;
         srarq_pkg::ST_TK_INC: state_in = srarq_pkg::ST_TK_RD;
         srarq_pkg::ST_TK_RD: begin
            state_in = sts.tk_more ? srarq_pkg::ST_TK_CHK : srarq_pkg::ST_EM_SEL;
         end
         srarq_pkg::ST_TK_CHK: state_in = srarq_pkg::ST_TK_RD;
         srarq_pkg::ST_EM_SEL: begin
            if (sts.mask_zero) begin
               state_in = srarq_pkg::ST_IDLE;
            end else if (sts.mask_bit) begin
               state_in = srarq_pkg::ST_EM_OUT;
            end
         end
         srarq_pkg::ST_EM_OUT: state_in = srarq_pkg::ST_EM_SEL;
         default:              state_in = srarq_pkg::ST_IDLE;
      endcase
   end

   // datapath commands
   always_comb begin
      ctl  = '0;
      busy = 1'b1;
      case (state_ff)
         srarq_pkg::ST_CLEAR: ctl.clr_step = 1'b1;
         srarq_pkg::ST_IDLE: begin
            busy         = 1'b0;
            ctl.latch_in = start;
         end
         srarq_pkg::ST_LOAD:   ctl.load_do = 1'b1;
         srarq_pkg::ST_ACK_RD: ctl.ack_rd  = 1'b1;
         srarq_pkg::ST_ACK_WR: ctl.ack_wr  = 1'b1;
         srarq_pkg::ST_SL_RD:  ctl.sl_rd   = sts.sl_more;
         srarq_pkg::ST_SL_CHK: ctl.sl_adv  = sts.sl_acked;
         srarq_pkg::ST_FIN:    ctl.flag_upd = 1'b1;
         srarq_pkg::ST_STATUS: ctl.emit_status = 1'b1;
         srarq_pkg::ST_TK_INC: ctl.tk_inc  = 1'b1;
         srarq_pkg::ST_TK_RD: begin
            ctl.tk_rd   = sts.tk_more;
            ctl.k_clear = !sts.tk_more;
         end
         srarq_pkg::ST_TK_CHK: ctl.tk_chk = 1'b1;
         srarq_pkg::ST_EM_SEL: begin
            ctl.em_rd  = !sts.mask_zero && sts.mask_bit;
            ctl.k_step = !sts.mask_zero && !sts.mask_bit;
         end
         srarq_pkg::ST_EM_OUT: ctl.em_out = 1'b1;
         default: ctl = '0;
      endcase
   end

endmodule

`default_nettype wire

>>> sv/srarq_dp.sv
`default_nettype none

module srarq_dp #(
   parameter int MAX_FRAMES  = 256,
   parameter int WINDOW_SIZE = 8
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire srarq_pkg::dp_ctl_type                 ctl,
   output srarq_pkg::dp_sts_type                      sts,
   input  wire logic [srarq_pkg::CMD_W-1:0]           req_cmd,
   input  wire logic [srarq_pkg::PAYLOAD_W-1:0]       req_payload,
   input  wire logic [srarq_pkg::RX_W-1:0]            req_rx_word,
   input  wire logic                                  csr_we,
   input  wire logic [srarq_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [srarq_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output logic                                       rsp_strobe,
   output logic                                       rsp_kind,
   output logic [srarq_pkg::SEQ_W-1:0]                rsp_seq_char,
   output logic [srarq_pkg::PAYLOAD_W-1:0]            rsp_frame_data,
   output logic [srarq_pkg::INDEX_W-1:0]              rsp_frame_index,
   output logic [srarq_pkg::COUNT_W-1:0]              rsp_acked_count,
   output logic                                       rsp_done_res,
   output logic                                       rsp_last
);

   localparam int AW    = $clog2(MAX_FRAMES);
   localparam int IDX_W = $clog2(MAX_FRAMES + WINDOW_SIZE);
   localparam int CW    = (IDX_W > srarq_pkg::TOTAL_W) ? IDX_W : srarq_pkg::TOTAL_W;
   localparam int K_W   = $clog2(WINDOW_SIZE + 1);
   localparam int KI_W  = $clog2(WINDOW_SIZE);
   localparam int SW    = srarq_pkg::TICK_W + 1;
   localparam int TW    = srarq_pkg::TICK_W;

   // configuration and latched item
   logic [srarq_pkg::TOTAL_W-1:0]   total_ff, total_in;
   logic [srarq_pkg::TIMEOUT_W-1:0] timeout_ff, timeout_in;
   srarq_pkg::cmd_type              cmd_ff, cmd_in;
   logic [srarq_pkg::PAYLOAD_W-1:0] payload_ff, payload_in;
   logic [srarq_pkg::RX_W-1:0]      rx_ff, rx_in;

   // sender state
   logic [AW-1:0]          clr_addr_ff, clr_addr_in;
   logic [IDX_W-1:0]       base_ff, base_in;
   logic [IDX_W-1:0]       load_ff, load_in;
   logic [TW-1:0]          tick_ff, tick_in;
   logic                   complete_ff, complete_in;
   logic [K_W-1:0]         k_ff, k_in;
   logic [WINDOW_SIZE-1:0] mask_ff, mask_in;

   // result registers
   logic                              strobe_ff, strobe_in;
   logic                              kind_ff, kind_in;
   logic [srarq_pkg::SEQ_W-1:0]       seq_ff, seq_in;
   logic [srarq_pkg::PAYLOAD_W-1:0]   data_ff, data_in;
   logic [srarq_pkg::INDEX_W-1:0]     index_ff, index_in;
   logic [srarq_pkg::COUNT_W-1:0]     count_ff, count_in;
   logic                              done_ff, done_in;
   logic                              last_ff, last_in;

   // memories
   logic                            st_we, st_re;
   logic [AW-1:0]                   st_waddr, st_raddr;
   logic [SW-1:0]                   st_wdata, st_rd;
   logic                            fr_we;
   logic [srarq_pkg::PAYLOAD_W-1:0] fr_rd;

   // derived values
   logic [CW-1:0]          tot_wide, base_wide, win_wide;
   logic [IDX_W-1:0]       tot;
   logic [7:0]             digit;
   logic                   ack_word;
   logic [2:0]             ack_k;
   logic [IDX_W-1:0]       ack_idx;
   logic                   ack_hit;
   logic [IDX_W-1:0]       win_idx;
   logic [KI_W-1:0]        k_bit;
   logic [WINDOW_SIZE-1:0] k_onehot;
   logic [TW-1:0]          age;
   logic                   expired;
   logic                   load_room;

   // effective total, capped at the store depth
   assign tot_wide = (CW'(total_ff) > CW'(MAX_FRAMES)) ? CW'(MAX_FRAMES) : CW'(total_ff);
   assign tot      = tot_wide[IDX_W-1:0];

   // ack decode: window slot whose index low bits match the digit
   assign digit    = rx_ff[7:0];
   assign ack_word = (rx_ff[31:8] == srarq_pkg::ACK_TAG) &&
                     (digit >= srarq_pkg::CHAR_ZERO) && (digit <= srarq_pkg::CHAR_SEVEN);
   assign ack_k    = digit[2:0] - base_ff[2:0];
   assign ack_idx  = base_ff + IDX_W'(ack_k);
   assign ack_hit  = ack_word && ({29'd0, ack_k} < 32'(WINDOW_SIZE)) &&
                     (ack_idx < tot) && (ack_idx < load_ff);

   // window scan position
   assign win_idx  = base_ff + IDX_W'(k_ff);
   assign k_bit    = k_ff[KI_W-1:0];
   assign k_onehot = WINDOW_SIZE'(1) << k_bit;

   // wrap-safe expiry
   assign age     = tick_ff - st_rd[TW-1:0];
   assign expired = !st_rd[TW] && (age > TW'(timeout_ff));

   assign load_room = load_ff < IDX_W'(MAX_FRAMES);
   assign base_wide = CW'(base_ff);
   assign win_wide  = CW'(win_idx);

   // status to controller
   always_comb begin
      sts.clear_done = (clr_addr_ff == AW'(MAX_FRAMES - 1));
      sts.cmd        = cmd_ff;
      sts.sl_more    = base_ff < tot;
      sts.sl_acked   = st_rd[TW];
      sts.tk_more    = (k_ff < K_W'(WINDOW_SIZE)) && (win_idx < tot) && (win_idx < load_ff);
      sts.mask_zero  = (mask_ff == '0);
      sts.mask_bit   = mask_ff[k_bit];
   end

   // acked flag and send stamp store
   always_comb begin
      st_we    = 1'b0;
      st_waddr = win_idx[AW-1:0];
      st_wdata = {1'b0, tick_ff};
      if (ctl.clr_step) begin
         st_we    = 1'b1;
         st_waddr = clr_addr_ff;
         st_wdata = '0;
      end else if (ctl.ack_wr) begin
         st_we    = ack_hit;
         st_waddr = ack_idx[AW-1:0];
         st_wdata = {1'b1, st_rd[TW-1:0]};
      end else if (ctl.tk_chk) begin
         st_we    = expired;
      end
   end

   always_comb begin
      st_re = ctl.ack_rd || ctl.sl_rd || ctl.tk_rd;
      if (ctl.ack_rd) begin
         st_raddr = ack_idx[AW-1:0];
      end else if (ctl.sl_rd) begin
         st_raddr = base_ff[AW-1:0];
      end else begin
         st_raddr = win_idx[AW-1:0];
      end
   end

   srarq_ram #(
      .WIDTH (SW),
      .DEPTH (MAX_FRAMES)
   ) u_stamp_ram (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (st_waddr),
      .wr_data (st_wdata),
      .rd_en   (st_re),
      .rd_addr (st_raddr),
      .rd_data (st_rd)
   );

   // frame payload store
   assign fr_we = ctl.load_do && load_room;

   srarq_ram #(
      .WIDTH (srarq_pkg::PAYLOAD_W),
      .DEPTH (MAX_FRAMES)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (fr_we),
      .wr_addr (load_ff[AW-1:0]),
      .wr_data (payload_ff & srarq_pkg::PAYLOAD_MASK),
      .rd_en   (ctl.em_rd),
      .rd_addr (win_idx[AW-1:0]),
      .rd_data (fr_rd)
   );

   // configuration writes and item latch
   always_comb begin
      total_in   = total_ff;
      timeout_in = timeout_ff;
      if (csr_we) begin
         case (csr_index)
            srarq_pkg::CSR_TOTAL_FRAMES:  total_in   = csr_wdata[srarq_pkg::TOTAL_W-1:0];
            srarq_pkg::CSR_TIMEOUT_TICKS: timeout_in = csr_wdata;
            default: ;
         endcase
      end
      cmd_in     = ctl.latch_in ? srarq_pkg::cmd_type'(req_cmd) : cmd_ff;
      payload_in = ctl.latch_in ? req_payload : payload_ff;
      rx_in      = ctl.latch_in ? req_rx_word : rx_ff;
   end

   // sender state updates
   always_comb begin
      clr_addr_in = ctl.clr_step ? clr_addr_ff + AW'(1) : clr_addr_ff;
      load_in     = fr_we ? load_ff + IDX_W'(1) : load_ff;
      base_in     = ctl.sl_adv ? base_ff + IDX_W'(1) : base_ff;
      tick_in     = ctl.tk_inc ? tick_ff + TW'(1) : tick_ff;
      complete_in = complete_ff || (ctl.flag_upd && (base_ff >= tot));
      k_in        = k_ff;
      mask_in     = mask_ff;
      if (ctl.tk_inc || ctl.k_clear) begin
         k_in = '0;
      end else if (ctl.tk_chk || ctl.k_step || ctl.em_out) begin
         k_in = k_ff + K_W'(1);
      end
      if (ctl.tk_inc) begin
         mask_in = '0;
      end else if (ctl.tk_chk && expired) begin
         mask_in = mask_ff | k_onehot;
      end else if (ctl.em_out) begin
         mask_in = mask_ff & ~k_onehot;
      end
   end

   // result beat
   always_comb begin
      strobe_in = ctl.emit_status || ctl.em_out;
      kind_in   = kind_ff;
      seq_in    = seq_ff;
      data_in   = data_ff;
      index_in  = index_ff;
      count_in  = count_ff;
      done_in   = done_ff;
      last_in   = last_ff;
      if (ctl.emit_status) begin
         kind_in  = 1'b1;
         seq_in   = '0;
         data_in  = '0;
         index_in = '0;
         count_in = base_wide[srarq_pkg::COUNT_W-1:0];
         done_in  = complete_ff;
         last_in  = 1'b1;
      end else if (ctl.em_out) begin
         kind_in  = 1'b0;
         seq_in   = srarq_pkg::CHAR_ZERO + {5'd0, win_idx[2:0]};
         data_in  = fr_rd;
         index_in = win_wide[srarq_pkg::INDEX_W-1:0];
         count_in = base_wide[srarq_pkg::COUNT_W-1:0];
         done_in  = complete_ff;
         last_in  = ((mask_ff & ~k_onehot) == '0);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff    <= srarq_pkg::TOTAL_RESET;
         timeout_ff  <= srarq_pkg::TIMEOUT_RESET;
         clr_addr_ff <= '0;
         base_ff     <= '0;
         load_ff     <= '0;
         tick_ff     <= '0;
         complete_ff <= 1'b0;
         k_ff        <= '0;
         mask_ff     <= '0;
         strobe_ff   <= 1'b0;
      end else begin
         total_ff    <= total_in;
         timeout_ff  <= timeout_in;
         clr_addr_ff <= clr_addr_in;
         base_ff     <= base_in;
         load_ff     <= load_in;
         tick_ff     <= tick_in;
         complete_ff <= complete_in;
         k_ff        <= k_in;
         mask_ff     <= mask_in;
         strobe_ff   <= strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      payload_ff <= payload_in;
      rx_ff      <= rx_in;
      kind_ff    <= kind_in;
      seq_ff     <= seq_in;
      data_ff    <= data_in;
      index_ff   <= index_in;
      count_ff   <= count_in;
      done_ff    <= done_in;
      last_ff    <= last_in;
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_seq_char    = seq_ff;
   assign rsp_frame_data  = data_ff;
   assign rsp_frame_index = index_ff;
   assign rsp_acked_count = count_ff;
   assign rsp_done_res    = done_ff;
   assign rsp_last        = last_ff;

endmodule

`default_nettype wire

>>> sv/selective_repeat_arq_sender.sv
// a load writes its payload to the frame store while there is room, then a status beat;
//   a message marks its ack slot, slides the base over acked frames, then a status beat
// a tick: advances the tick count, checks each frame in the window for expiry, then
//   resends the expired frames in window order; one item at a time, taken only while idle
// reset: clearing pass over every address of the acked/stamp store with busy high;
//   result beats cannot be stalled by the receiver
`default_nettype none

module selective_repeat_arq_sender #(
   parameter int MAX_FRAMES  = 256,
   parameter int WINDOW_SIZE = 8
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   output logic                                       busy,
   input  wire logic [srarq_pkg::CMD_W-1:0]           req_cmd,
   input  wire logic [srarq_pkg::PAYLOAD_W-1:0]       req_payload,
   input  wire logic [srarq_pkg::RX_W-1:0]            req_rx_word,
   output logic                                       rsp_strobe,
   output logic                                       rsp_kind,
   output logic [srarq_pkg::SEQ_W-1:0]                rsp_seq_char,
   output logic [srarq_pkg::PAYLOAD_W-1:0]            rsp_frame_data,
   output logic [srarq_pkg::INDEX_W-1:0]              rsp_frame_index,
   output logic [srarq_pkg::COUNT_W-1:0]              rsp_acked_count,
   output logic                                       rsp_done_res,
   output logic                                       rsp_last,
   input  wire logic                                  csr_we,
   input  wire logic [srarq_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [srarq_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   srarq_pkg::dp_ctl_type ctl;
   srarq_pkg::dp_sts_type sts;

   // sequencer
   srarq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .ctl   (ctl),
      .sts   (sts)
   );

   // stores, counters and result registers
   srarq_dp #(
      .MAX_FRAMES  (MAX_FRAMES),
      .WINDOW_SIZE (WINDOW_SIZE)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .ctl             (ctl),
      .sts             (sts),
      .req_cmd         (req_cmd),
      .req_payload     (req_payload),
      .req_rx_word     (req_rx_word),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_strobe      (rsp_strobe),
      .rsp_kind        (rsp_kind),
      .rsp_seq_char    (rsp_seq_char),
      .rsp_frame_data  (rsp_frame_data),
      .rsp_frame_index (rsp_frame_index),
      .rsp_acked_count (rsp_acked_count),
      .rsp_done_res    (rsp_done_res),
      .rsp_last        (rsp_last)
   );

endmodule

`default_nettype wire

>>> sv/srarq_checker.sv
`default_nettype none

module srarq_checker (
   input wire logic                                  clock,
   input wire logic                                  reset,
   input wire logic                                  start,
   input wire logic                                  busy,
   input wire logic                                  rsp_strobe,
   input wire logic                                  rsp_kind,
   input wire logic [srarq_pkg::SEQ_W-1:0]           rsp_seq_char,
   input wire logic [srarq_pkg::PAYLOAD_W-1:0]       rsp_frame_data,
   input wire logic [srarq_pkg::INDEX_W-1:0]         rsp_frame_index,
   input wire logic                                  rsp_last
);

   // reset starts the clearing pass with no beat out
   a_reset_clear: assert property (@(posedge clock)
      reset |=> busy && !rsp_strobe)
      else $error("no clearing pass after reset");

   // an accepted item keeps the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("not busy after accept");

   // status beat carries no frame and closes its item
   a_status_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_kind) |-> (rsp_frame_data == '0) && (rsp_seq_char == '0) &&
                                   (rsp_frame_index == '0) && rsp_last && !busy)
      else $error("malformed status beat");

   // sequence character follows the frame index
   a_seq_char: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_kind) |->
         (rsp_seq_char == (srarq_pkg::CHAR_ZERO + {5'd0, rsp_frame_index[2:0]})))
      else $error("sequence character mismatch");

   // a frame beat that is not last is followed by more work
   a_frame_more: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_kind && !rsp_last) |-> busy)
      else $error("idle before last frame beat");

endmodule

bind selective_repeat_arq_sender srarq_checker u_srarq_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_strobe      (rsp_strobe),
   .rsp_kind        (rsp_kind),
   .rsp_seq_char    (rsp_seq_char),
   .rsp_frame_data  (rsp_frame_data),
   .rsp_frame_index (rsp_frame_index),
   .rsp_last        (rsp_last)
);

`default_nettype wire
